FILE: hw/rtl/lome_pkg.sv
`default_nettype none
package lome_pkg;

	// Matched levels allowed per request
	localparam int LEVEL_CAP = 16;
	localparam int LEVEL_W = 5;

	typedef struct packed {
		logic        kind;
		logic        instrument;
		logic        side;
		logic [31:0] order_id;
		logic [15:0] price;
		logic [23:0] quantity;
		logic [31:0] target_id;
	} req_t;

	typedef struct packed {
		logic [2:0]  report_kind;
		logic [31:0] report_order_id;
		logic [15:0] report_price;
		logic [23:0] leaves_quantity;
		logic        last;
	} rpt_t;

	typedef struct packed {
		logic [15:0] price;
		logic [31:0] owner;
		logic [23:0] qty;
	} entry_t;

	typedef enum logic [2:0] {
		RK_ACK     = 3'd0,
		RK_FILL    = 3'd1,
		RK_PARTIAL = 3'd2,
		RK_CXL_OK  = 3'd3,
		RK_CXL_REJ = 3'd4,
		RK_DROP    = 3'd5
	} rpt_kind_t;

	// Which book a scan walks and how it picks its entry
	typedef enum logic [1:0] {
		SEL_OPP,
		SEL_OWN,
		SEL_CXL
	} scan_sel_t;

	typedef enum logic [2:0] {
		PS_ACK,
		PS_M1,
		PS_M2,
		PS_CXL_OK,
		PS_CXL_REJ,
		PS_DROP
	} push_sel_t;

	typedef struct packed {
		logic      capture;
		logic      scan_start;
		scan_sel_t scan_sel;
		logic      push;
		push_sel_t push_sel;
		logic      match_apply;
		logic      rest_write;
		logic      cxl_clear;
		logic      cxl_next;
		logic      drop_merge;
		logic      fin;
	} ctl_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic found;
		logic crosses;
		logic qty_zero;
		logic is_cancel;
		logic leaves_zero;
		logic level_cap;
		logic book_full;
		logic cxl_last;
		logic push_ok;
		logic out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/limit_order_matching_engine.sv
// Limit order matching engine for two instruments with four price-ordered books
// (buy and sell each), BOOK_DEPTH entries per book, one resting order per price.
// Requests are taken one at a time; req_stall stays high until the last report of
// the current request has been handed to the output register. All book searches go
// through the single read port of the entry memory, one slot per cycle. A new order
// matches at most 16 levels; when a remainder is left, a final crossing check and
// the resting search follow (only the resting search once the level limit is hit).
// A cancel searches up to four books in turn. Stalls on the report side lengthen
// the time req_stall is held. No clearing pass is needed after reset: per-entry
// valid bits are cleared at once.
`default_nettype none
module limit_order_matching_engine #(
	parameter int BOOK_DEPTH = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire lome_pkg::req_t req,
	output logic                rpt_valid,
	input  wire logic           rpt_stall,
	output lome_pkg::rpt_t      rpt
);

	lome_pkg::ctl_cmd_t cmd;
	lome_pkg::dp_stat_t stat;
	logic               idle;

	assign req_stall = !idle;

	lome_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (req_valid && idle),
		.stat   (stat),
		.idle   (idle),
		.cmd    (cmd)
	);

	lome_dp #(
		.BOOK_DEPTH (BOOK_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.rpt_stall (rpt_stall),
		.stat      (stat),
		.rpt       (rpt),
		.rpt_valid (rpt_valid)
	);

endmodule
`default_nettype wire

FILE: hw/rtl/lome_ram.sv
`default_nettype none
module lome_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

FILE: hw/rtl/lome_ctrl.sv
`default_nettype none
module lome_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire lome_pkg::dp_stat_t stat,
	output logic                   idle,
	output lome_pkg::ctl_cmd_t     cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACK,
		ST_MSCAN,
		ST_MEVAL,
		ST_MREP1,
		ST_MREP2,
		ST_RSCAN,
		ST_REVAL,
		ST_CSCAN,
		ST_CEVAL,
		ST_FIN
	} state_t;

	state_t state_q, state_d;

	assign idle = (state_q == ST_IDLE);

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					state_d = ST_ACK;
				end
			end
			ST_ACK: begin
				if (stat.is_cancel) begin
					cmd.scan_start = 1'b1;
					cmd.scan_sel = lome_pkg::SEL_CXL;
					state_d = ST_CSCAN;
				end else if (stat.push_ok) begin
					cmd.push = 1'b1;
					cmd.push_sel = lome_pkg::PS_ACK;
					if (stat.qty_zero) begin
						state_d = ST_FIN;
					end else begin
						cmd.scan_start = 1'b1;
						cmd.scan_sel = lome_pkg::SEL_OPP;
						state_d = ST_MSCAN;
					end
				end
			end
			ST_MSCAN: begin
				if (stat.scan_done) state_d = ST_MEVAL;
			end
			ST_MEVAL: begin
				if (stat.found && stat.crosses) begin
					state_d = ST_MREP1;
				end else begin
					cmd.scan_start = 1'b1;
					cmd.scan_sel = lome_pkg::SEL_OWN;
					state_d = ST_RSCAN;
				end
			end
			ST_MREP1: begin
				if (stat.push_ok) begin
					cmd.push = 1'b1;
					cmd.push_sel = lome_pkg::PS_M1;
					cmd.match_apply = 1'b1;
					state_d = ST_MREP2;
				end
			end
			ST_MREP2: begin
				if (stat.push_ok) begin
					cmd.push = 1'b1;
					cmd.push_sel = lome_pkg::PS_M2;
					if (stat.leaves_zero) begin
						state_d = ST_FIN;
					end else if (stat.level_cap) begin
						cmd.scan_start = 1'b1;
						cmd.scan_sel = lome_pkg::SEL_OWN;
						state_d = ST_RSCAN;
					end else begin
						cmd.scan_start = 1'b1;
						cmd.scan_sel = lome_pkg::SEL_OPP;
						state_d = ST_MSCAN;
					end
				end
			end
			ST_RSCAN: begin
				if (stat.scan_done) state_d = ST_REVAL;
			end
			ST_REVAL: begin
				if (!stat.book_full) begin
					cmd.rest_write = 1'b1;
					state_d = ST_FIN;
				end else if (stat.level_cap) begin
					// no room for another report: the held one becomes the drop
					cmd.drop_merge = 1'b1;
					state_d = ST_FIN;
				end else if (stat.push_ok) begin
					cmd.push = 1'b1;
					cmd.push_sel = lome_pkg::PS_DROP;
					state_d = ST_FIN;
				end
			end
			ST_CSCAN: begin
				if (stat.scan_done) state_d = ST_CEVAL;
			end
			ST_CEVAL: begin
				if (stat.found) begin
					if (stat.push_ok) begin
						cmd.push = 1'b1;
						cmd.push_sel = lome_pkg::PS_CXL_OK;
						cmd.cxl_clear = 1'b1;
						state_d = ST_FIN;
					end
				end else if (stat.cxl_last) begin
					if (stat.push_ok) begin
						cmd.push = 1'b1;
						cmd.push_sel = lome_pkg::PS_CXL_REJ;
						state_d = ST_FIN;
					end
				end else begin
					cmd.cxl_next = 1'b1;
					cmd.scan_start = 1'b1;
					cmd.scan_sel = lome_pkg::SEL_CXL;
					state_d = ST_CSCAN;
				end
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/lome_dp.sv
`default_nettype none
module lome_dp #(
	parameter int BOOK_DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lome_pkg::req_t     req,
	input  wire lome_pkg::ctl_cmd_t cmd,
	input  wire logic               rpt_stall,
	output lome_pkg::dp_stat_t      stat,
	output lome_pkg::rpt_t          rpt,
	output logic                    rpt_valid
);

	localparam int SW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
	localparam int AW = SW + 2;
	localparam int EW = $bits(lome_pkg::entry_t);

	lome_pkg::req_t   req_q;
	logic [23:0]      leaves_q;
	logic [lome_pkg::LEVEL_W-1:0] levels_q;
	logic [1:0]       cxl_k_q;
	logic [1:0]       cxl_k_d;
	logic [1:0]       book_q;
	lome_pkg::scan_sel_t mode_q;
	logic [BOOK_DEPTH-1:0] valid_q [4];

	// scan engine
	logic             run_q;
	logic [SW-1:0]    slot_q;
	logic             rd_v_s1;
	logic [SW-1:0]    rd_slot_s1;
	lome_pkg::entry_t rd_ent;
	logic [EW-1:0]    rd_data;
	logic             take;
	logic             better;

	// best candidate of the current scan
	logic             found_q;
	logic [SW-1:0]    best_slot_q;
	logic [15:0]      best_price_q;
	logic [31:0]      best_owner_q;
	logic [23:0]      best_qty_q;

	// report holding and output stage
	logic             pend_valid_q;
	lome_pkg::rpt_t   pend_q;
	lome_pkg::rpt_t   pend_out;
	lome_pkg::rpt_t   rep2_q;
	logic             out_valid_q;
	lome_pkg::rpt_t   out_q;
	logic             out_free;
	lome_pkg::rpt_t   new_rpt;
	lome_pkg::rpt_t   m1_rpt;
	lome_pkg::rpt_t   m2_rpt;
	logic [23:0]      m_leaves;
	logic             m_keep;

	logic             free_found;
	logic [SW-1:0]    free_slot;

	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	lome_pkg::entry_t wr_ent;

	assign cxl_k_d = cmd.cxl_next ? cxl_k_q + 2'd1 : cxl_k_q;
	assign out_free = !out_valid_q || !rpt_stall;
	assign rd_ent = lome_pkg::entry_t'(rd_data);

	// Candidate selection on returning read data
	always_comb begin
		better = !found_q ||
			(book_q[0] ? (rd_ent.price < best_price_q) : (rd_ent.price > best_price_q));
		take = 1'b0;
		if (rd_v_s1 && valid_q[book_q][rd_slot_s1]) begin
			unique case (mode_q)
				lome_pkg::SEL_OPP: take = better;
				lome_pkg::SEL_CXL: take = better && (rd_ent.owner == req_q.target_id);
				lome_pkg::SEL_OWN: take = !found_q && (rd_ent.price == req_q.price);
				default:           take = 1'b0;
			endcase
		end
	end

	// First free slot in the current book
	always_comb begin
		free_found = 1'b0;
		free_slot = '0;
		for (int i = 0; i < BOOK_DEPTH; i++) begin
			if (!free_found && !valid_q[book_q][i]) begin
				free_found = 1'b1;
				free_slot = SW'(i);
			end
		end
	end

	// Reports of one matched level
	always_comb begin
		m1_rpt = '0;
		m2_rpt = '0;
		m_leaves = '0;
		m_keep = 1'b0;
		m1_rpt.report_kind = lome_pkg::RK_FILL;
		m1_rpt.report_price = best_price_q;
		m2_rpt.report_price = best_price_q;
		if (leaves_q < best_qty_q) begin
			m1_rpt.report_order_id = req_q.order_id;
			m2_rpt.report_kind = lome_pkg::RK_PARTIAL;
			m2_rpt.report_order_id = best_owner_q;
			m2_rpt.leaves_quantity = best_qty_q - leaves_q;
			m_keep = 1'b1;
		end else if (leaves_q > best_qty_q) begin
			m1_rpt.report_order_id = best_owner_q;
			m2_rpt.report_kind = lome_pkg::RK_PARTIAL;
			m2_rpt.report_order_id = req_q.order_id;
			m2_rpt.leaves_quantity = leaves_q - best_qty_q;
			m_leaves = leaves_q - best_qty_q;
		end else begin
			m1_rpt.report_order_id = req_q.order_id;
			m2_rpt.report_kind = lome_pkg::RK_FILL;
			m2_rpt.report_order_id = best_owner_q;
		end
	end

	// Report to be pushed
	always_comb begin
		new_rpt = '0;
		unique case (cmd.push_sel)
			lome_pkg::PS_ACK: begin
				new_rpt.report_kind = lome_pkg::RK_ACK;
				new_rpt.report_order_id = req_q.order_id;
				new_rpt.report_price = req_q.price;
				new_rpt.leaves_quantity = req_q.quantity;
			end
			lome_pkg::PS_M1: new_rpt = m1_rpt;
			lome_pkg::PS_M2: new_rpt = rep2_q;
			lome_pkg::PS_CXL_OK: begin
				new_rpt.report_kind = lome_pkg::RK_CXL_OK;
				new_rpt.report_order_id = req_q.order_id;
				new_rpt.report_price = best_price_q;
				new_rpt.leaves_quantity = best_qty_q;
			end
			lome_pkg::PS_CXL_REJ: begin
				new_rpt.report_kind = lome_pkg::RK_CXL_REJ;
				new_rpt.report_order_id = req_q.order_id;
			end
			lome_pkg::PS_DROP: begin
				new_rpt.report_kind = lome_pkg::RK_DROP;
				new_rpt.report_order_id = req_q.order_id;
				new_rpt.report_price = req_q.price;
				new_rpt.leaves_quantity = leaves_q;
			end
			default: new_rpt = '0;
		endcase
	end

	// Held report with its last flag, as it moves to the output register
	always_comb begin
		pend_out = pend_q;
		pend_out.last = cmd.fin;
	end

	// Entry memory write port
	always_comb begin
		wr_en = 1'b0;
		wr_addr = {book_q, best_slot_q};
		wr_ent.price = best_price_q;
		wr_ent.owner = best_owner_q;
		wr_ent.qty = best_qty_q - leaves_q;
		if (cmd.match_apply && m_keep) begin
			wr_en = 1'b1;
		end else if (cmd.rest_write) begin
			wr_en = 1'b1;
			wr_addr = {book_q, found_q ? best_slot_q : free_slot};
			wr_ent.price = req_q.price;
			wr_ent.owner = req_q.order_id;
			wr_ent.qty = leaves_q;
		end
	end

	lome_ram #(
		.WIDTH (EW),
		.DEPTH (4 << SW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (EW'(wr_ent)),
		.rd_addr ({book_q, slot_q}),
		.rd_data (rd_data)
	);

	// Request and match bookkeeping
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
			leaves_q <= req.quantity;
		end else if (cmd.match_apply) begin
			leaves_q <= m_leaves;
			rep2_q <= m2_rpt;
		end
		if (cmd.scan_start) begin
			mode_q <= cmd.scan_sel;
			unique case (cmd.scan_sel)
				lome_pkg::SEL_OPP: book_q <= {req_q.instrument, ~req_q.side};
				lome_pkg::SEL_OWN: book_q <= {req_q.instrument, req_q.side};
				lome_pkg::SEL_CXL: book_q <= {cxl_k_d[0], ~cxl_k_d[1]};
				default:           book_q <= book_q;
			endcase
		end
		if (take) begin
			best_slot_q <= rd_slot_s1;
			best_price_q <= rd_ent.price;
			best_owner_q <= rd_ent.owner;
			best_qty_q <= rd_ent.qty;
		end
		rd_slot_s1 <= slot_q;
		if (cmd.scan_start) begin
			slot_q <= '0;
		end else if (run_q) begin
			slot_q <= slot_q + SW'(1);
		end
	end

	// Control state: scan, counters, valid bits, report path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			rd_v_s1 <= 1'b0;
			found_q <= 1'b0;
			levels_q <= '0;
			cxl_k_q <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			for (int b = 0; b < 4; b++) valid_q[b] <= '0;
		end else begin
			rd_v_s1 <= run_q;
			if (cmd.scan_start) begin
				run_q <= 1'b1;
				found_q <= 1'b0;
			end else begin
				if (run_q && slot_q == SW'(BOOK_DEPTH - 1)) run_q <= 1'b0;
				if (take) found_q <= 1'b1;
			end
			if (cmd.capture) begin
				levels_q <= '0;
				cxl_k_q <= '0;
			end else begin
				if (cmd.match_apply) levels_q <= levels_q + lome_pkg::LEVEL_W'(1);
				cxl_k_q <= cxl_k_d;
			end
			if ((cmd.match_apply && !m_keep) || cmd.cxl_clear) begin
				valid_q[book_q][best_slot_q] <= 1'b0;
			end else if (cmd.rest_write) begin
				valid_q[book_q][found_q ? best_slot_q : free_slot] <= 1'b1;
			end
			// one report is held back until it is known whether it is the last
			if (cmd.push || cmd.fin) begin
				if (pend_valid_q) begin
					out_q <= pend_out;
					out_valid_q <= 1'b1;
				end else if (!rpt_stall) begin
					out_valid_q <= 1'b0;
				end
				pend_valid_q <= cmd.push;
				pend_q <= new_rpt;
			end else begin
				if (cmd.drop_merge) pend_q.report_kind <= lome_pkg::RK_DROP;
				if (!rpt_stall) out_valid_q <= 1'b0;
			end
		end
	end

	assign rpt = out_q;
	assign rpt_valid = out_valid_q;

	always_comb begin
		stat.scan_done = !run_q && !rd_v_s1;
		stat.found = found_q;
		stat.crosses = req_q.side ? (req_q.price <= best_price_q)
			: (req_q.price >= best_price_q);
		stat.qty_zero = (req_q.quantity == '0);
		stat.is_cancel = req_q.kind;
		stat.leaves_zero = (leaves_q == '0);
		stat.level_cap = (levels_q == lome_pkg::LEVEL_W'(lome_pkg::LEVEL_CAP));
		stat.book_full = !found_q && !free_found;
		stat.cxl_last = (cxl_k_q == 2'd3);
		stat.push_ok = !pend_valid_q || out_free;
		stat.out_free = out_free;
	end

`ifndef ASSERT_OFF
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push && pend_valid_q) |-> out_free) else $error("report overwritten");
	a_fin_pend: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> pend_valid_q) else $error("finish without held report");
	a_level_cap: assert property (@(posedge clk) disable iff (!arst_n)
		levels_q <= lome_pkg::LEVEL_W'(lome_pkg::LEVEL_CAP)) else $error("level cap passed");
	a_apply_found: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.match_apply || cmd.cxl_clear) |-> found_q) else $error("apply without entry");
`endif

endmodule
`default_nettype wire

FILE: verif/tb_limit_order_matching_engine.sv
`timescale 1ns / 1ps
module tb_limit_order_matching_engine;

	localparam int DEPTH = 16;
	localparam int NBOOK = 4;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int REQ_W = $bits(lome_pkg::req_t);

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	lome_pkg::req_t req;
	logic rpt_valid;
	logic rpt_stall;
	lome_pkg::rpt_t rpt;

	limit_order_matching_engine #(.BOOK_DEPTH(DEPTH)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rpt_valid(rpt_valid),
		.rpt_stall(rpt_stall),
		.rpt(rpt)
	);

	// Book mirror, index = book*DEPTH + slot
	logic        book_live [NBOOK*DEPTH];
	logic [15:0] book_px   [NBOOK*DEPTH];
	logic [31:0] book_own  [NBOOK*DEPTH];
	logic [23:0] book_qty  [NBOOK*DEPTH];

	lome_pkg::rpt_t expected_reports[$];
	int   mismatch_count = 0;
	int   cycle_count = 0;
	bit   quiet_mode;     // no random idling in this stretch
	logic [31:0] next_id;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		$display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, want,
			cycle_count);
	endtask

	function automatic void queue_report(input lome_pkg::rpt_kind_t kind,
			input logic [31:0] id, input logic [15:0] px, input logic [23:0] leaves);
		lome_pkg::rpt_t r;
		r.report_kind = kind;
		r.report_order_id = id;
		r.report_price = px;
		r.leaves_quantity = leaves;
		r.last = 1'b0;
		expected_reports = {expected_reports, r};
	endfunction

	// Best live entry in a book, optionally restricted to one owner; -1 if none
	function automatic int best_level(input int bk, input bit by_owner,
			input logic [31:0] owner);
		int best;
		int e;
		best = -1;
		for (int i = 0; i < DEPTH; i++) begin
			e = bk*DEPTH + i;
			if (!book_live[e]) continue;
			if (by_owner && book_own[e] != owner) continue;
			if (best < 0) best = e;
			else if (bk[0] ? (book_px[e] < book_px[best]) : (book_px[e] > book_px[best]))
				best = e;
		end
		return best;
	endfunction

	function automatic bit rest_in_book(input int bk, input logic [31:0] id,
			input logic [15:0] px, input logic [23:0] qty);
		int slot;
		slot = -1;
		for (int i = 0; i < DEPTH && slot < 0; i++)
			if (book_live[bk*DEPTH+i] && book_px[bk*DEPTH+i] == px) slot = bk*DEPTH+i;
		for (int i = 0; i < DEPTH && slot < 0; i++)
			if (!book_live[bk*DEPTH+i]) slot = bk*DEPTH+i;
		if (slot < 0) return 1'b0;
		book_live[slot] = 1'b1;
		book_px[slot] = px;
		book_own[slot] = id;
		book_qty[slot] = qty;
		return 1'b1;
	endfunction

	// Expected reports of one request, appended to expected_reports
	function automatic void predict_reports(input lome_pkg::req_t r);
		int bk;
		int e;
		int levels;
		int produced;
		logic [23:0] leaves;
		logic [23:0] rq;
		logic [15:0] lp;
		int cxl_order[4];
		produced = 0;
		if (r.kind == 1'b0) begin
			bk = int'({r.instrument, r.side});
			leaves = r.quantity;
			levels = 0;
			queue_report(lome_pkg::RK_ACK, r.order_id, r.price, r.quantity);
			produced = 1;
			while (r.quantity != 0 && leaves != 0 && levels < lome_pkg::LEVEL_CAP) begin
				e = best_level(bk ^ 1, 1'b0, '0);
				if (e < 0) break;
				lp = book_px[e];
				if (r.side ? (r.price > lp) : (r.price < lp)) break;
				levels++;
				rq = book_qty[e];
				if (leaves < rq) begin
					book_qty[e] = rq - leaves;
					queue_report(lome_pkg::RK_FILL, r.order_id, lp, '0);
					queue_report(lome_pkg::RK_PARTIAL, book_own[e], lp, rq - leaves);
					leaves = '0;
				end else if (leaves > rq) begin
					leaves = leaves - rq;
					queue_report(lome_pkg::RK_FILL, book_own[e], lp, '0);
					queue_report(lome_pkg::RK_PARTIAL, r.order_id, lp, leaves);
					book_live[e] = 1'b0;
				end else begin
					queue_report(lome_pkg::RK_FILL, r.order_id, lp, '0);
					queue_report(lome_pkg::RK_FILL, book_own[e], lp, '0);
					book_live[e] = 1'b0;
					leaves = '0;
				end
				produced += 2;
			end
			if (r.quantity != 0 && leaves != 0 &&
					!rest_in_book(bk, r.order_id, r.price, leaves)) begin
				if (produced < 33)
					queue_report(lome_pkg::RK_DROP, r.order_id, r.price, leaves);
				else
					expected_reports[expected_reports.size()-1].report_kind =
						lome_pkg::RK_DROP;
			end
		end else begin
			cxl_order = '{1, 3, 0, 2};
			e = -1;
			for (int k = 0; k < 4 && e < 0; k++)
				e = best_level(cxl_order[k], 1'b1, r.target_id);
			if (e >= 0) begin
				book_live[e] = 1'b0;
				queue_report(lome_pkg::RK_CXL_OK, r.order_id, book_px[e], book_qty[e]);
			end else
				queue_report(lome_pkg::RK_CXL_REJ, r.order_id, '0, '0);
		end
		expected_reports[expected_reports.size()-1].last = 1'b1;
	endfunction

	// Send one request; prediction happens at acceptance
	task automatic send_request(input lome_pkg::req_t r);
		while (!quiet_mode && $urandom_range(99) < 23) begin
			req_valid <= 1'b0;
			req <= lome_pkg::req_t'(REQ_W'({$urandom, $urandom, $urandom, $urandom}));
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		predict_reports(r);
	endtask

	// Report side: random stall and field check
	always @(posedge clk or negedge arst_n) begin
		lome_pkg::rpt_t want;
		if (!arst_n) begin
			rpt_stall <= 1'b1;
		end else begin
			if (rpt_valid && !rpt_stall) begin
				if (expected_reports.size() == 0)
					report_mismatch("unexpected report", rpt.report_order_id, '0);
				else begin
					want = expected_reports.pop_front();
					if (rpt.report_kind != want.report_kind)
						report_mismatch("report_kind", 32'(rpt.report_kind),
							32'(want.report_kind));
					if (rpt.report_order_id != want.report_order_id)
						report_mismatch("report_order_id", rpt.report_order_id,
							want.report_order_id);
					if (rpt.report_price != want.report_price)
						report_mismatch("report_price", 32'(rpt.report_price),
							32'(want.report_price));
					if (rpt.leaves_quantity != want.leaves_quantity)
						report_mismatch("leaves_quantity", 32'(rpt.leaves_quantity),
							32'(want.leaves_quantity));
					if (rpt.last != want.last)
						report_mismatch("last", 32'(rpt.last), 32'(want.last));
				end
			end
			rpt_stall <= quiet_mode ? 1'b0 : ($urandom_range(99) < 23);
		end
	end

	function automatic lome_pkg::req_t make_order(input bit inst, input bit sd,
			input logic [15:0] px, input logic [23:0] qty);
		lome_pkg::req_t r;
		r = lome_pkg::req_t'(REQ_W'({$urandom, $urandom, $urandom, $urandom}));
		r.kind = 1'b0;
		r.instrument = inst;
		r.side = sd;
		r.order_id = next_id;
		r.price = px;
		r.quantity = qty;
		next_id = next_id + 32'd1;
		return r;
	endfunction

	function automatic lome_pkg::req_t make_cancel(input logic [31:0] target);
		lome_pkg::req_t r;
		r = lome_pkg::req_t'(REQ_W'({$urandom, $urandom, $urandom, $urandom}));
		r.kind = 1'b1;
		r.order_id = $urandom;
		r.target_id = target;
		return r;
	endfunction

	// Field extremes, zero quantity, exact and partial fills, cancel hit and miss
	task automatic test_directed_basics();
		lome_pkg::req_t r;
		send_request(make_order(1'b0, 1'b0, 16'hFFFF, 24'hFFFFFF));
		send_request(make_order(1'b0, 1'b1, 16'h0000, 24'd1));
		send_request(make_order(1'b1, 1'b1, 16'd100, 24'd0));
		send_request(make_order(1'b1, 1'b1, 16'd100, 24'd50));
		send_request(make_order(1'b1, 1'b0, 16'd100, 24'd20));
		send_request(make_order(1'b1, 1'b0, 16'd100, 24'd30));
		send_request(make_order(1'b1, 1'b0, 16'd99, 24'd10));
		send_request(make_order(1'b1, 1'b1, 16'd99, 24'd10));
		send_request(make_cancel(32'd0));
		send_request(make_cancel(32'hFFFFFFFF));
		r = make_order(1'b0, 1'b0, 16'd500, 24'd7);
		r.order_id = 32'hFFFFFFFF;
		send_request(r);
		send_request(make_order(1'b0, 1'b0, 16'd500, 24'd9));  // replaces same price
		send_request(make_cancel(32'hFFFFFFFF));
		send_request(make_order(1'b1, 1'b0, 16'd40, 24'd5));
		send_request(make_cancel(next_id - 32'd1));
	endtask

	// Fill one book, overflow it, then sweep all levels with one big order
	task automatic test_full_book_sweep();
		for (int i = 0; i < DEPTH; i++)
			send_request(make_order(1'b1, 1'b1, 16'd1000 + 16'(i), 24'd3));
		send_request(make_order(1'b1, 1'b1, 16'd2000, 24'd4));
		send_request(make_order(1'b1, 1'b0, 16'hFFFF, 24'hFFFFFF));
		for (int i = 0; i < DEPTH; i++)
			send_request(make_order(1'b1, 1'b0, 16'd500 + 16'(i), 24'd2));
		send_request(make_order(1'b1, 1'b1, 16'd0, 24'd100));
	endtask

	// Random traffic: small price band so orders cross, cancels mostly of recent ids
	task automatic test_random_traffic(input int count, input bit calm);
		logic [31:0] target;
		int pick;
		quiet_mode = calm;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 75)
				send_request(make_order(1'($urandom_range(1)), 1'($urandom_range(1)),
					($urandom_range(9) == 0) ? 16'($urandom) : 16'(300 + $urandom_range(20)),
					($urandom_range(9) == 0) ? 24'($urandom) :
					($urandom_range(19) == 0) ? 24'd0 : 24'($urandom_range(1, 60))));
			else begin
				target = ($urandom_range(3) == 0) ? $urandom : next_id - $urandom_range(1, 30);
				send_request(make_cancel(target));
			end
		end
		quiet_mode = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		quiet_mode = 1'b0;
		next_id = 32'd1;
		for (int i = 0; i < NBOOK*DEPTH; i++) begin
			book_live[i] = 1'b0;
			book_px[i] = '0;
			book_own[i] = '0;
			book_qty[i] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_basics();
		test_full_book_sweep();
		test_random_traffic(300, 1'b0);
		test_random_traffic(60, 1'b1);
		test_random_traffic(60, 1'b0);
		req_valid <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
